[rtl/nested_region_profiler_defines.svh]
// Assertion macros shared by the profiler's checker.
`ifndef NESTED_REGION_PROFILER_DEFINES_SVH
`define NESTED_REGION_PROFILER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define NRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define NRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/nrp_pkg.sv]
// Types, sizes and codes for the nested region profiler.
package nrp_pkg;

	localparam int NUM_REGIONS = 64;
	localparam int STACK_DEPTH = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int RegionW = 8;
	localparam int ByteW   = 32;
	localparam int TimeW   = 48;
	localparam int HitW    = 32;
	localparam int AccW    = 48;
	localparam int RegIdxW = $clog2(NUM_REGIONS);
	localparam int StkIdxW = $clog2(STACK_DEPTH);
	localparam int DepthW  = $clog2(STACK_DEPTH + 1);
	localparam int QIdxW   = $clog2(QUEUE_DEPTH);
	localparam int QCntW   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DepthW-1:0] FullDepth = DepthW'(STACK_DEPTH);

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_END   = 2'd1,
		CMD_ADD   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_MODIFY
	} back_state_t;

	// One event beat
	typedef struct packed {
		cmd_t               cmd;
		logic [RegionW-1:0] region;
		logic [ByteW-1:0]   byte_count;
		logic [TimeW-1:0]   timestamp;
	} evt_t;

	// One result beat
	typedef struct packed {
		status_t           status;
		logic [HitW-1:0]   hit_count;
		logic [AccW-1:0]   exclusive_time;
		logic [AccW-1:0]   inclusive_time;
		logic [AccW-1:0]   byte_total;
		logic [DepthW-1:0] open_depth;
	} res_t;

	// Counter operation handed from front to back
	typedef struct packed {
		logic               upd;
		logic               hit;
		logic               report;
		status_t            status;
		logic [RegIdxW-1:0] region;
		logic [TimeW-1:0]   excl_add;
		logic [TimeW-1:0]   incl_add;
		logic [ByteW-1:0]   byte_add;
		logic [DepthW-1:0]  depth;
	} op_t;

	// Per-region counter word
	typedef struct packed {
		logic [HitW-1:0] hits;
		logic [AccW-1:0] excl;
		logic [AccW-1:0] incl;
		logic [AccW-1:0] bytes;
	} ctr_t;

endpackage

[rtl/nrp_if.sv]
// Valid/ready channel interfaces for events and results.
interface nrp_evt_if;
	logic          valid;
	logic          ready;
	nrp_pkg::evt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nrp_res_if;
	logic          valid;
	logic          ready;
	nrp_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/nrp_queue.sv]
// Short operation queue between the front and the back.
module nrp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nrp_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output nrp_pkg::op_t  head_op,
	output logic          empty
);

	nrp_pkg::op_t                   slot_q [nrp_pkg::QUEUE_DEPTH];
	logic [nrp_pkg::QIdxW-1:0]      wr_ptr_q;
	logic [nrp_pkg::QIdxW-1:0]      rd_ptr_q;
	logic [nrp_pkg::QCntW-1:0]      cnt_q;
	logic                           do_push;
	logic                           do_pop;

	localparam logic [nrp_pkg::QIdxW-1:0] LastIdx = nrp_pkg::QIdxW'(nrp_pkg::QUEUE_DEPTH - 1);
	localparam logic [nrp_pkg::QCntW-1:0] FullCnt = nrp_pkg::QCntW'(nrp_pkg::QUEUE_DEPTH);

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head_op = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[rtl/nrp_front.sv]
// Front end: takes events, keeps the open-region stack, emits counter operations.
module nrp_front (
	input  logic         clk,
	input  logic         arst_n,
	nrp_evt_if.sink      evt,
	input  logic         q_full,
	output logic         push,
	output nrp_pkg::op_t push_op
);

	logic [nrp_pkg::RegIdxW-1:0] stk_region_q [nrp_pkg::STACK_DEPTH];
	logic [nrp_pkg::TimeW-1:0]   resume_q     [nrp_pkg::STACK_DEPTH];
	logic [nrp_pkg::TimeW-1:0]   start_q      [nrp_pkg::STACK_DEPTH];
	logic [nrp_pkg::DepthW-1:0]  depth_q;
	logic                        phase_q;

	logic [nrp_pkg::StkIdxW-1:0] top_idx;
	logic [nrp_pkg::StkIdxW-1:0] par_idx;
	logic [nrp_pkg::StkIdxW-1:0] new_idx;
	logic                        region_ok;
	logic                        is_empty;
	logic                        is_full;
	logic [nrp_pkg::RegIdxW-1:0] top_region;
	logic [nrp_pkg::TimeW-1:0]   excl_el;
	logic [nrp_pkg::TimeW-1:0]   incl_el;
	logic                        need_parent;
	logic                        accept;
	logic                        stk_push;
	logic                        stk_pop;
	logic [nrp_pkg::DepthW-1:0]  depth_d;

	// Stack addressing and elapsed ticks of the top activation
	assign top_idx    = nrp_pkg::StkIdxW'(depth_q - nrp_pkg::DepthW'(1));
	assign par_idx    = nrp_pkg::StkIdxW'(depth_q - nrp_pkg::DepthW'(2));
	assign new_idx    = nrp_pkg::StkIdxW'(depth_q);
	assign region_ok  = {1'b0, evt.data.region} < (nrp_pkg::RegionW + 1)'(nrp_pkg::NUM_REGIONS);
	assign is_empty   = (depth_q == '0);
	assign is_full    = (depth_q == nrp_pkg::FullDepth);
	assign top_region = stk_region_q[top_idx];
	assign excl_el    = evt.data.timestamp - resume_q[top_idx];
	assign incl_el    = evt.data.timestamp - start_q[top_idx];

	// A begin under an open parent first charges the parent, then pushes
	assign need_parent = (evt.data.cmd == nrp_pkg::CMD_BEGIN) && region_ok && !is_full && !is_empty;
	assign evt.ready   = !q_full && !(need_parent && !phase_q);
	assign push        = evt.valid && !q_full;
	assign accept      = evt.valid && evt.ready;

	// Classify the event
	always_comb begin
		push_op          = '0;
		push_op.report   = 1'b1;
		push_op.status   = nrp_pkg::ST_OK;
		push_op.region   = top_region;
		push_op.depth    = depth_q;
		depth_d          = depth_q;
		stk_push         = 1'b0;
		stk_pop          = 1'b0;
		case (evt.data.cmd)
			nrp_pkg::CMD_BEGIN: begin
				if (!region_ok) begin
					push_op.status = nrp_pkg::ST_RANGE;
				end else if (is_full) begin
					push_op.status = nrp_pkg::ST_FULL;
				end else if (need_parent && !phase_q) begin
					push_op.upd      = 1'b1;
					push_op.report   = 1'b0;
					push_op.excl_add = excl_el;
				end else begin
					push_op.upd      = 1'b1;
					push_op.hit      = 1'b1;
					push_op.region   = evt.data.region[nrp_pkg::RegIdxW-1:0];
					push_op.byte_add = evt.data.byte_count;
					depth_d          = depth_q + 1'b1;
					push_op.depth    = depth_d;
					stk_push         = 1'b1;
				end
			end
			nrp_pkg::CMD_END: begin
				if (is_empty) begin
					push_op.status = nrp_pkg::ST_EMPTY;
				end else begin
					push_op.upd      = 1'b1;
					push_op.excl_add = excl_el;
					push_op.incl_add = incl_el;
					depth_d          = depth_q - 1'b1;
					push_op.depth    = depth_d;
					stk_pop          = 1'b1;
				end
			end
			nrp_pkg::CMD_ADD: begin
				if (is_empty) begin
					push_op.status = nrp_pkg::ST_EMPTY;
				end else begin
					push_op.upd      = 1'b1;
					push_op.byte_add = evt.data.byte_count;
				end
			end
			nrp_pkg::CMD_READ: begin
				if (!region_ok) begin
					push_op.status = nrp_pkg::ST_RANGE;
				end else begin
					push_op.region = evt.data.region[nrp_pkg::RegIdxW-1:0];
				end
			end
			default: begin
				push_op.status = nrp_pkg::ST_OK;
			end
		endcase
	end

	// Depth and parent-charge phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (accept) begin
				depth_q <= depth_d;
				phase_q <= 1'b0;
			end else if (push && need_parent) begin
				phase_q <= 1'b1;
			end
		end
	end

	// Stack entries
	always_ff @(posedge clk) begin
		if (accept && stk_push) begin
			stk_region_q[new_idx] <= evt.data.region[nrp_pkg::RegIdxW-1:0];
			resume_q[new_idx]     <= evt.data.timestamp;
			start_q[new_idx]      <= evt.data.timestamp;
		end
		if (accept && stk_pop && (depth_q > nrp_pkg::DepthW'(1))) begin
			resume_q[par_idx] <= evt.data.timestamp;
		end
	end

endmodule

[rtl/nrp_back.sv]
// Back end: read-modify-write of the per-region counters and the result register.
module nrp_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  nrp_pkg::op_t head_op,
	output logic         q_pop,
	nrp_res_if.source    res
);

	nrp_pkg::ctr_t         ctr_mem [nrp_pkg::NUM_REGIONS];
	logic [nrp_pkg::NUM_REGIONS-1:0] vld_q;
	nrp_pkg::back_state_t  state_q;
	nrp_pkg::back_state_t  state_d;
	nrp_pkg::op_t          op_q;
	nrp_pkg::ctr_t         rd_q;
	logic                  rd_vld_q;
	logic                  res_valid_q;
	nrp_pkg::res_t         res_data_q;

	nrp_pkg::ctr_t         cur;
	nrp_pkg::ctr_t         nxt;
	logic                  out_free;
	logic                  done;
	logic                  wr_en;
	logic                  res_load;
	nrp_pkg::res_t         res_d;

	function automatic logic [nrp_pkg::AccW-1:0] sat_add(
		input logic [nrp_pkg::AccW-1:0] a,
		input logic [nrp_pkg::AccW-1:0] b
	);
		logic [nrp_pkg::AccW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[nrp_pkg::AccW] ? '1 : sum[nrp_pkg::AccW-1:0];
	endfunction

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nrp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = nrp_pkg::BK_MODIFY;
				end
			end
			nrp_pkg::BK_MODIFY: begin
				if (done) begin
					state_d = nrp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = nrp_pkg::BK_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		q_pop = 1'b0;
		done  = 1'b0;
		case (state_q)
			nrp_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			nrp_pkg::BK_MODIFY: begin
				done = !op_q.report || out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign out_free = !res_valid_q || res.ready;
	assign wr_en    = done && op_q.upd;
	assign res_load = done && op_q.report;

	// Counter update; never-written regions read as zero
	always_comb begin
		cur       = rd_vld_q ? rd_q : '0;
		nxt.hits  = (op_q.hit && (cur.hits != '1)) ? cur.hits + 1'b1 : cur.hits;
		nxt.excl  = sat_add(cur.excl, op_q.excl_add);
		nxt.incl  = sat_add(cur.incl, op_q.incl_add);
		nxt.bytes = sat_add(cur.bytes, nrp_pkg::AccW'(op_q.byte_add));
	end

	// Result beat: counters only on success
	always_comb begin
		res_d            = '0;
		res_d.status     = op_q.status;
		res_d.open_depth = op_q.depth;
		if (op_q.status == nrp_pkg::ST_OK) begin
			res_d.hit_count      = nxt.hits;
			res_d.exclusive_time = nxt.excl;
			res_d.inclusive_time = nxt.incl;
			res_d.byte_total     = nxt.bytes;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nrp_pkg::BK_IDLE;
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[op_q.region] <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Operation capture, counter memory and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q     <= head_op;
			rd_q     <= ctr_mem[head_op.region];
			rd_vld_q <= vld_q[head_op.region];
		end
		if (wr_en) begin
			ctr_mem[op_q.region] <= nxt;
		end
		if (res_load) begin
			res_data_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule

[rtl/nested_region_profiler.sv]
// Nested region profiler: top level joining front, queue and back.
// Channels: evt (sink) takes one event beat per handshake: cmd, region,
// byte_count, timestamp. res (source) gives exactly one result beat per
// event, in event order: status, hit_count, exclusive_time, inclusive_time,
// byte_total and open_depth after the event.
// Flow: a taken event is pushed into the queue, popped by the back end,
// and its result is loaded into the result register once the output is free.
// A begin while a region is open is accepted only after a charge operation
// for the paused parent, which gives no result, has been queued first.
// The back end handles one operation at a time, reading the counter word
// when it pops the operation and writing it back when the operation is done.
// Reset (arst_n low): stack empty, all per-region counters read as zero,
// no result pending. A valid bit per region marks words written since reset.
// Receiver stall: the result register holds its beat; the four-deep queue
// keeps absorbing events until full, then evt.ready drops.
module nested_region_profiler (
	input  logic       clk,
	input  logic       arst_n,
	nrp_evt_if.sink    evt,
	nrp_res_if.source  res
);

	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_empty;
	nrp_pkg::op_t push_op;
	nrp_pkg::op_t head_op;

	nrp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.q_full  (q_full),
		.push    (q_push),
		.push_op (push_op)
	);

	nrp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.head_op (head_op),
		.empty   (q_empty)
	);

	nrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head_op (head_op),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

[rtl/nrp_checker.sv]
// Port-level checker for the profiler, bound to the top level.
`include "nested_region_profiler_defines.svh"

module nrp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input nrp_pkg::res_t res_data
);

	// Refused events report no counters
	`NRP_ASSERT_IMP(a_err_zero, res_valid && (res_data.status != nrp_pkg::ST_OK), (res_data.hit_count == '0) && (res_data.exclusive_time == '0) && (res_data.inclusive_time == '0) && (res_data.byte_total == '0), "refused event carries counter values")

	// Stack-full refusal only with every slot open
	`NRP_ASSERT_IMP(a_full_depth, res_valid && (res_data.status == nrp_pkg::ST_FULL), res_data.open_depth == nrp_pkg::FullDepth, "stack full reported below full depth")

	// Stack-empty refusal only with nothing open
	`NRP_ASSERT_IMP(a_empty_depth, res_valid && (res_data.status == nrp_pkg::ST_EMPTY), res_data.open_depth == '0, "stack empty reported with regions open")

	// A stalled result beat holds
	`NRP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result beat changed while stalled")

endmodule

bind nested_region_profiler nrp_checker u_nrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
